>>> design/moog_ladder_lowpass_macros.svh
// Assertion macros for the ladder filter. Each macro samples on the rising
// edge of i_clk and is switched off while i_rst_n is low.
`ifndef MOOG_LADDER_LOWPASS_MACROS_SVH
`define MOOG_LADDER_LOWPASS_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MLL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ladder filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MLL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ladder filter assertion failed");

`else

`define MLL_ASSERT_SAME(lbl, ante, cons)
`define MLL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/mll_pkg.sv
package mll_pkg;

    localparam int DATA_WIDTH = 24;
    localparam int FRAC_BITS  = 20;

    // Width of the rounded quotient numerator t = (|num| + 3*2^F) >> (F+1).
    localparam int T_W    = 2 * DATA_WIDTH - FRAC_BITS - 2;
    localparam int GAIN_W = 24;
    localparam int MUL_W  = (DATA_WIDTH > T_W + 1)
                            ? ((DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W)
                            : ((T_W + 1 > GAIN_W) ? T_W + 1 : GAIN_W);
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int CLIP_W = ((T_W > DATA_WIDTH) ? T_W : DATA_WIDTH) + 2;

    // Reciprocal of three, rounded up, scaled by 2^(T_W+1).
    localparam longint RECIP_L = ((64'sd1 <<< (T_W + 1)) + 64'sd2) / 3;
    localparam logic [T_W-1:0] RECIP3 = T_W'(RECIP_L);

    // Configuration register widths and reset values.
    localparam int P_W = 21;
    localparam int K_W = 22;
    localparam int R_W = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 2;
    localparam logic        [P_W-1:0] P_RESET = 21'd83873;
    localparam logic signed [K_W-1:0] K_RESET = -22'sd899306;
    localparam logic        [R_W-1:0] R_RESET = 23'd373467;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLE_GAIN      = 2'd0,
        CFG_POLE_FEEDBACK  = 2'd1,
        CFG_RESONANCE_GAIN = 2'd2
    } t_cfg_idx;

    // Microprogram length and step counter width.
    localparam int N_STEPS = 26;
    localparam int STEP_W  = $clog2(N_STEPS);

    typedef enum logic [3:0] {
        A_IN, A_X, A_S0, A_S1, A_S2, A_S3, A_D0, A_D1, A_D2, A_D3, A_SQ, A_T
    } t_asel;

    typedef enum logic [2:0] {
        B_P, B_K, B_R, B_ONE, B_M3, B_S3
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
    } t_accop;

    typedef enum logic [3:0] {
        WB_NONE, WB_X, WB_S0, WB_S1, WB_S2, WB_S3, WB_SQ, WB_T, WB_CLIP
    } t_wb;

    typedef enum logic [1:0] {
        J_NEXT, J_WAIT_IN, J_END
    } t_jump;

    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        t_accop acc_op;
        t_wb    wb;
        t_jump  jump;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_status;

    function automatic t_ctrl mll_word(t_asel a, t_bsel b, t_accop op, t_wb wb, t_jump j);
        t_ctrl w;
        w.a_sel  = a;
        w.b_sel  = b;
        w.acc_op = op;
        w.wb     = wb;
        w.jump   = j;
        return w;
    endfunction

    // The microprogram. The product of step n is registered and taken into
    // the accumulator by step n+1; a write-back reads the accumulator as it
    // stood at the start of its step.
    function automatic t_ctrl mll_ucode(logic [STEP_W-1:0] step);
        t_ctrl w;
        case (int'(step))
            0:  w = mll_word(A_IN, B_ONE, ACC_HOLD, WB_NONE, J_WAIT_IN);
            1:  w = mll_word(A_IN, B_ONE, ACC_HOLD, WB_NONE, J_NEXT);
            2:  w = mll_word(A_S3, B_R,   ACC_LOAD, WB_NONE, J_NEXT);
            3:  w = mll_word(A_D0, B_P,   ACC_SUB,  WB_NONE, J_NEXT);
            4:  w = mll_word(A_S0, B_K,   ACC_LOAD, WB_X,    J_NEXT);
            5:  w = mll_word(A_X,  B_P,   ACC_SUB,  WB_NONE, J_NEXT);
            6:  w = mll_word(A_D1, B_P,   ACC_ADD,  WB_NONE, J_NEXT);
            7:  w = mll_word(A_S1, B_K,   ACC_LOAD, WB_S0,   J_NEXT);
            8:  w = mll_word(A_S0, B_P,   ACC_SUB,  WB_NONE, J_NEXT);
            9:  w = mll_word(A_D2, B_P,   ACC_ADD,  WB_NONE, J_NEXT);
            10: w = mll_word(A_S2, B_K,   ACC_LOAD, WB_S1,   J_NEXT);
            11: w = mll_word(A_S1, B_P,   ACC_SUB,  WB_NONE, J_NEXT);
            12: w = mll_word(A_D3, B_P,   ACC_ADD,  WB_NONE, J_NEXT);
            13: w = mll_word(A_S3, B_K,   ACC_LOAD, WB_S2,   J_NEXT);
            14: w = mll_word(A_S2, B_P,   ACC_SUB,  WB_NONE, J_NEXT);
            15: w = mll_word(A_S2, B_P,   ACC_ADD,  WB_NONE, J_NEXT);
            16: w = mll_word(A_S3, B_S3,  ACC_HOLD, WB_S3,   J_NEXT);
            17: w = mll_word(A_S3, B_S3,  ACC_HOLD, WB_NONE, J_NEXT);
            18: w = mll_word(A_SQ, B_S3,  ACC_LOAD, WB_NONE, J_NEXT);
            19: w = mll_word(A_SQ, B_S3,  ACC_HOLD, WB_SQ,   J_NEXT);
            20: w = mll_word(A_SQ, B_S3,  ACC_HOLD, WB_NONE, J_NEXT);
            21: w = mll_word(A_T,  B_M3,  ACC_LOAD, WB_NONE, J_NEXT);
            22: w = mll_word(A_T,  B_M3,  ACC_HOLD, WB_T,    J_NEXT);
            23: w = mll_word(A_T,  B_M3,  ACC_HOLD, WB_NONE, J_NEXT);
            24: w = mll_word(A_T,  B_M3,  ACC_LOAD, WB_NONE, J_NEXT);
            25: w = mll_word(A_T,  B_M3,  ACC_HOLD, WB_CLIP, J_END);
            default: w = mll_word(A_IN, B_ONE, ACC_HOLD, WB_NONE, J_END);
        endcase
        return w;
    endfunction

endpackage

>>> design/mll_sequencer.sv
module mll_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mll_pkg::t_status i_status,
    output mll_pkg::t_ctrl  o_ctrl
);

    logic [mll_pkg::STEP_W-1:0] r_step;
    logic [mll_pkg::STEP_W-1:0] n_step;
    mll_pkg::t_ctrl             s_word;
    logic                       s_advance;

    assign s_word = mll_pkg::mll_ucode(r_step);

    always_comb begin
        case (s_word.jump)
            mll_pkg::J_WAIT_IN: s_advance = i_status.in_valid;
            mll_pkg::J_END:     s_advance = i_status.out_free;
            default:            s_advance = 1'b1;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (s_advance) begin
            if (s_word.jump == mll_pkg::J_END) begin
                n_step = '0;
            end else begin
                n_step = r_step + mll_pkg::STEP_W'(1);
            end
        end
    end

    // A step that is held waiting must not repeat its write-back.
    always_comb begin
        o_ctrl = s_word;
        if (!s_advance) begin
            o_ctrl.wb = mll_pkg::WB_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> design/mll_datapath.sv
module mll_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mll_pkg::t_ctrl                       i_ctrl,
    input  logic                                 i_load,
    input  logic signed [mll_pkg::DATA_WIDTH-1:0] i_sample,
    input  logic        [mll_pkg::P_W-1:0]        i_pole_gain,
    input  logic signed [mll_pkg::K_W-1:0]        i_pole_feedback,
    input  logic        [mll_pkg::R_W-1:0]        i_resonance_gain,
    output logic signed [mll_pkg::DATA_WIDTH-1:0] o_clip
);

    localparam int DW = mll_pkg::DATA_WIDTH;
    localparam int MW = mll_pkg::MUL_W;
    localparam int AW = mll_pkg::ACC_W;
    localparam int TW = mll_pkg::T_W;
    localparam int CW = mll_pkg::CLIP_W;
    localparam int FB = mll_pkg::FRAC_BITS;

    localparam logic [MW-1:0] ONE      = MW'(1) << FB;
    localparam logic [AW-1:0] RND_HALF = AW'(1) << (FB - 1);
    localparam logic [AW-1:0] Q_HALF   = AW'(3) << FB;

    logic signed [DW-1:0] r_in, r_x, r_sq;
    logic signed [DW-1:0] r_s0, r_s1, r_s2, r_s3;
    logic signed [DW-1:0] r_d0, r_d1, r_d2, r_d3;
    logic        [TW-1:0] r_t;
    logic                 r_neg;
    logic signed [mll_pkg::PROD_W-1:0] r_prod;
    logic signed [AW-1:0] r_acc;

    logic signed [MW-1:0] s_op_a, s_op_b;
    logic signed [AW-1:0] s_rsum, s_rshift;
    logic signed [DW-1:0] s_rnd;
    logic        [AW-1:0] s_mag, s_tsum;
    logic        [TW-1:0] s_q;
    logic signed [CW-1:0] s_qext, s_diff;

    always_comb begin
        case (i_ctrl.a_sel)
            mll_pkg::A_IN: s_op_a = MW'(r_in);
            mll_pkg::A_X:  s_op_a = MW'(r_x);
            mll_pkg::A_S0: s_op_a = MW'(r_s0);
            mll_pkg::A_S1: s_op_a = MW'(r_s1);
            mll_pkg::A_S2: s_op_a = MW'(r_s2);
            mll_pkg::A_S3: s_op_a = MW'(r_s3);
            mll_pkg::A_D0: s_op_a = MW'(r_d0);
            mll_pkg::A_D1: s_op_a = MW'(r_d1);
            mll_pkg::A_D2: s_op_a = MW'(r_d2);
            mll_pkg::A_D3: s_op_a = MW'(r_d3);
            mll_pkg::A_SQ: s_op_a = MW'(r_sq);
            mll_pkg::A_T:  s_op_a = MW'(r_t);
            default:       s_op_a = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.b_sel)
            mll_pkg::B_P:   s_op_b = MW'(i_pole_gain);
            mll_pkg::B_K:   s_op_b = MW'(i_pole_feedback);
            mll_pkg::B_R:   s_op_b = MW'(i_resonance_gain);
            mll_pkg::B_ONE: s_op_b = ONE;
            mll_pkg::B_M3:  s_op_b = MW'(mll_pkg::RECIP3);
            mll_pkg::B_S3:  s_op_b = MW'(r_s3);
            default:        s_op_b = '0;
        endcase
    end

    // Round half up to FRAC_BITS, then saturate to the data width.
    always_comb begin
        s_rsum   = r_acc + $signed(RND_HALF);
        s_rshift = s_rsum >>> FB;
        if ((&s_rshift[AW-1:DW-1]) || !(|s_rshift[AW-1:DW-1])) begin
            s_rnd = s_rshift[DW-1:0];
        end else begin
            s_rnd = {s_rshift[AW-1], {(DW-1){~s_rshift[AW-1]}}};
        end
    end

    // Magnitude of the cubic numerator with half the divisor added; the
    // shift takes out 2^(F+1) of the divisor 6*2^F, leaving a divide by three.
    always_comb begin
        s_mag  = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
        s_tsum = s_mag + Q_HALF;
    end

    // The accumulator holds t times the scaled reciprocal of three here.
    always_comb begin
        s_q    = r_acc[TW+1 +: TW];
        s_qext = CW'($signed({1'b0, s_q}));
        s_diff = CW'(r_s3) - (r_neg ? -s_qext : s_qext);
        if ((&s_diff[CW-1:DW-1]) || !(|s_diff[CW-1:DW-1])) begin
            o_clip = s_diff[DW-1:0];
        end else begin
            o_clip = {s_diff[CW-1], {(DW-1){~s_diff[CW-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in <= i_sample;
        end
        r_prod <= s_op_a * s_op_b;
        case (i_ctrl.acc_op)
            mll_pkg::ACC_LOAD: r_acc <= AW'(r_prod);
            mll_pkg::ACC_ADD:  r_acc <= r_acc + AW'(r_prod);
            mll_pkg::ACC_SUB:  r_acc <= r_acc - AW'(r_prod);
            default:           r_acc <= r_acc;
        endcase
        case (i_ctrl.wb)
            mll_pkg::WB_X:  r_x  <= s_rnd;
            mll_pkg::WB_SQ: r_sq <= s_rnd;
            mll_pkg::WB_T: begin
                r_t   <= s_tsum[FB+1 +: TW];
                r_neg <= r_acc[AW-1];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_d0 <= '0;
            r_d1 <= '0;
            r_d2 <= '0;
            r_d3 <= '0;
        end else begin
            case (i_ctrl.wb)
                mll_pkg::WB_S0: r_s0 <= s_rnd;
                mll_pkg::WB_S1: r_s1 <= s_rnd;
                mll_pkg::WB_S2: r_s2 <= s_rnd;
                mll_pkg::WB_S3: r_s3 <= s_rnd;
                mll_pkg::WB_CLIP: begin
                    r_s3 <= o_clip;
                    r_d0 <= r_x;
                    r_d1 <= r_s0;
                    r_d2 <= r_s1;
                    r_d3 <= r_s2;
                end
                default: ;
            endcase
        end
    end

endmodule

>>> design/moog_ladder_lowpass.sv
// Four-pole resonant ladder lowpass working on signed Q3.20 samples, one
// transaction in and one transaction out per sample. An accepted sample is
// taken in the idle step, 24 further steps run the feedback sum, the four
// one-pole sections and the cubic soft clip, and the result is registered at
// the last step, from which the program returns to the idle step, so the next
// sample can be taken while the result is offered. The schedule is set by the
// single shared multiplier and accumulator, driven step by step from a 26-word
// microprogram held in a constant table. The result waits in an output
// register; if it has not been taken when the next result is ready, the last
// step holds until the output register frees. The gains p, k and resonance are
// written through the configuration channel, which is always ready, and should
// only be written while no sample is in progress. Writes to index 3 are ignored.
`include "moog_ladder_lowpass_macros.svh"

module moog_ladder_lowpass (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Sample input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [mll_pkg::DATA_WIDTH-1:0] i_sample_in,
    // Sample output channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [mll_pkg::DATA_WIDTH-1:0] o_sample_out,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mll_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mll_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic        [mll_pkg::P_W-1:0]        r_pole_gain;
    logic signed [mll_pkg::K_W-1:0]        r_pole_feedback;
    logic        [mll_pkg::R_W-1:0]        r_resonance_gain;
    logic                                  r_out_valid;
    logic signed [mll_pkg::DATA_WIDTH-1:0] r_out;

    mll_pkg::t_ctrl                        s_ctrl;
    mll_pkg::t_status                      s_status;
    logic                                  s_in_accept;
    logic signed [mll_pkg::DATA_WIDTH-1:0] s_clip;

    // Samples are only taken while the program sits in its idle step.
    assign o_in_stall  = (s_ctrl.jump != mll_pkg::J_WAIT_IN);
    assign s_in_accept = i_in_valid && !o_in_stall;

    // The output register is free when empty or when its transaction
    // completes in this cycle.
    assign s_status.in_valid = i_in_valid;
    assign s_status.out_free = !r_out_valid || !i_out_stall;

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    mll_sequencer u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (s_status),
        .o_ctrl   (s_ctrl)
    );

    mll_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (s_ctrl),
        .i_load           (s_in_accept),
        .i_sample         (i_sample_in),
        .i_pole_gain      (r_pole_gain),
        .i_pole_feedback  (r_pole_feedback),
        .i_resonance_gain (r_resonance_gain),
        .o_clip           (s_clip)
    );

    // Configuration registers. Values are used as written, cut to the width of each register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_gain      <= mll_pkg::P_RESET;
            r_pole_feedback  <= mll_pkg::K_RESET;
            r_resonance_gain <= mll_pkg::R_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mll_pkg::CFG_POLE_GAIN:      r_pole_gain      <= i_cfg_data[mll_pkg::P_W-1:0];
                mll_pkg::CFG_POLE_FEEDBACK:  r_pole_feedback  <= i_cfg_data[mll_pkg::K_W-1:0];
                mll_pkg::CFG_RESONANCE_GAIN: r_resonance_gain <= i_cfg_data[mll_pkg::R_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register: loaded by the clip step, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ctrl.wb == mll_pkg::WB_CLIP) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.wb == mll_pkg::WB_CLIP) begin
            r_out <= s_clip;
        end
    end

    // A new result only ever comes from the clip step.
    `MLL_ASSERT_SAME(a_out_from_clip, $rose(r_out_valid), $past(s_ctrl.wb == mll_pkg::WB_CLIP))
    // A result still waiting to be taken is never overwritten.
    `MLL_ASSERT_SAME(a_no_overwrite, r_out_valid && i_out_stall, s_ctrl.wb != mll_pkg::WB_CLIP)
    // Accepting a sample always starts the program.
    `MLL_ASSERT_NEXT(a_accept_starts, s_in_accept, s_ctrl.jump != mll_pkg::J_WAIT_IN)

endmodule
